// ===== hdl/v3a_pkg.sv =====
// ----------------------------------------------------------------------------
// v3a_pkg
// types, codes and helpers shared by the vec3 alu lanes and merge stage
// ----------------------------------------------------------------------------
`default_nettype none
package v3a_pkg;

  localparam int DATA_W          = 32;
  localparam int FRAC_BITS_DFLT  = 16;
  localparam int PROD_W          = 64;
  localparam int SQ_W            = 66;
  localparam int ROOT_W          = 33;

  localparam logic [2:0] OP_ADD   = 3'd0;
  localparam logic [2:0] OP_SUB   = 3'd1;
  localparam logic [2:0] OP_NEG   = 3'd2;
  localparam logic [2:0] OP_SCALE = 3'd3;
  localparam logic [2:0] OP_DOT   = 3'd4;
  localparam logic [2:0] OP_CROSS = 3'd5;
  localparam logic [2:0] OP_LEN   = 3'd6;
  localparam logic [2:0] OP_NORM  = 3'd7;

  // one lane's contribution to the merge stage
  typedef struct packed {
    logic signed [PROD_W+1:0] acc;   // lane result before rounding
    logic signed [DATA_W-1:0] a_val; // lane's own a component
  } lane_res_t;

  // clip to signed 32 bits
  function automatic logic [DATA_W:0] sat32(input logic signed [PROD_W+1:0] v);
    logic [DATA_W:0] res;
    if (v > 66'sh0_7FFF_FFFF) begin
      res = {1'b1, 32'h7FFF_FFFF};
    end else if (v < -66'sh0_8000_0000) begin
      res = {1'b1, 32'h8000_0000};
    end else begin
      res = {1'b0, v[DATA_W-1:0]};
    end
    return res;
  endfunction

endpackage
`default_nettype wire

// ===== hdl/vec3_alu.sv =====
// ----------------------------------------------------------------------------
// vec3_alu
// three-lane fixed-point vector alu with a merge, root and divide pipeline
// ----------------------------------------------------------------------------
// pipeline: lane registers, merge registers, 17 root stages, FRAC_BITS+33 divide stages, output register
// throughput: one item per cycle, busy is never raised, the receiver cannot stall
// the depth is set by the bit-per-stage divider used by normalize
// reset clears the valid pipeline only; out_valid is low after reset
`default_nettype none
module vec3_alu import v3a_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DFLT
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     start,
  output logic                          busy,
  input  wire logic [2:0]               in_operation,
  input  wire logic signed [DATA_W-1:0] in_a_x,
  input  wire logic signed [DATA_W-1:0] in_a_y,
  input  wire logic signed [DATA_W-1:0] in_a_z,
  input  wire logic signed [DATA_W-1:0] in_b_x,
  input  wire logic signed [DATA_W-1:0] in_b_y,
  input  wire logic signed [DATA_W-1:0] in_b_z,
  input  wire logic signed [DATA_W-1:0] in_scale_factor,
  output logic                          out_valid,
  output logic signed [DATA_W-1:0]      out_r_x,
  output logic signed [DATA_W-1:0]      out_r_y,
  output logic signed [DATA_W-1:0]      out_r_z,
  output logic signed [DATA_W-1:0]      out_scalar_out,
  output logic                          out_saturated
);

  localparam int SQ_ST  = ROOT_W / 2 + 1;
  localparam int NUM_W  = DATA_W + FRAC_BITS + 1;
  localparam int TAIL   = SQ_ST + NUM_W;
  localparam int DEPTH  = 2 + TAIL;
  localparam logic signed [PROD_W+1:0] HALF = (PROD_W+2)'(1) << (FRAC_BITS - 1);

  assign busy = 1'b0;

  lane_res_t           lr [3];
  logic [PROD_W-1:0]   sq [3];
  logic                en;

  assign en = 1'b1;

  v3a_lane u_lx (.clk, .en, .op(in_operation), .a_self(in_a_x), .b_self(in_b_x),
    .a_p(in_a_y), .b_q(in_b_z), .b_p(in_b_y), .a_q(in_a_z), .s_val(in_scale_factor),
    .res(lr[0]), .sq(sq[0]));
  v3a_lane u_ly (.clk, .en, .op(in_operation), .a_self(in_a_y), .b_self(in_b_y),
    .a_p(in_a_z), .b_q(in_b_x), .b_p(in_b_z), .a_q(in_a_x), .s_val(in_scale_factor),
    .res(lr[1]), .sq(sq[1]));
  v3a_lane u_lz (.clk, .en, .op(in_operation), .a_self(in_a_z), .b_self(in_b_z),
    .a_p(in_a_x), .b_q(in_b_y), .b_p(in_b_x), .a_q(in_a_y), .s_val(in_scale_factor),
    .res(lr[2]), .sq(sq[2]));

  // stage 1 control
  logic       v1_r;
  logic [2:0] op1_r;
  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else        v1_r <= start;
    op1_r <= in_operation;
  end

  // merge stage: rounding, dot sum, saturation, sum of squares
  logic [DATA_W:0]           sv [3];
  logic [DATA_W:0]           sd;
  logic signed [PROD_W+1:0]  dsum;
  logic [DATA_W-1:0]         vx_nxt [3];
  logic [DATA_W-1:0]         sc_nxt;
  logic                      sat_nxt;

  always_comb begin
    dsum = lr[0].acc + lr[1].acc + lr[2].acc;
    sd   = sat32((dsum + HALF) >>> FRAC_BITS);
    for (int i = 0; i < 3; i++) begin
      if (op1_r == OP_ADD || op1_r == OP_SUB || op1_r == OP_NEG) begin
        sv[i] = sat32(lr[i].acc);
      end else begin
        sv[i] = sat32((lr[i].acc + HALF) >>> FRAC_BITS);
      end
    end
    sat_nxt = 1'b0;
    sc_nxt  = '0;
    for (int i = 0; i < 3; i++) vx_nxt[i] = '0;
    case (op1_r)
      OP_DOT: begin
        sc_nxt  = sd[DATA_W-1:0];
        sat_nxt = sd[DATA_W];
      end
      OP_LEN, OP_NORM: ;
      default: begin
        for (int i = 0; i < 3; i++) vx_nxt[i] = sv[i][DATA_W-1:0];
        sat_nxt = sv[0][DATA_W] | sv[1][DATA_W] | sv[2][DATA_W];
      end
    endcase
  end

  logic                    v2_r;
  logic [2:0]              op2_r;
  logic [DATA_W-1:0]       vx2_r [3];
  logic [DATA_W-1:0]       sc2_r;
  logic                    sat2_r;
  logic signed [DATA_W-1:0] a2_r [3];
  logic [SQ_W-1:0]         ssq_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else        v2_r <= v1_r;
    op2_r  <= op1_r;
    sc2_r  <= sc_nxt;
    sat2_r <= sat_nxt;
    ssq_r  <= SQ_W'(sq[0]) + SQ_W'(sq[1]) + SQ_W'(sq[2]);
    for (int i = 0; i < 3; i++) begin
      vx2_r[i] <= vx_nxt[i];
      a2_r[i]  <= lr[i].a_val;
    end
  end

  // delay line holding the merged result while root and divide run
  typedef struct packed {
    logic                     v;
    logic [2:0]               op;
    logic [3*DATA_W-1:0]      vx;
    logic [DATA_W-1:0]        sc;
    logic                     sat;
    logic [3*DATA_W-1:0]      a;
  } dl_t;

  dl_t dl_r [TAIL+1];
  always_comb begin
    dl_r[0].v   = v2_r;
    dl_r[0].op  = op2_r;
    dl_r[0].vx  = {vx2_r[2], vx2_r[1], vx2_r[0]};
    dl_r[0].sc  = sc2_r;
    dl_r[0].sat = sat2_r;
    dl_r[0].a   = {a2_r[2], a2_r[1], a2_r[0]};
  end
  for (genvar s = 0; s < TAIL; s++) begin : g_dl
    always_ff @(posedge clk) begin
      if (!rst_n) dl_r[s+1].v <= 1'b0;
      else        dl_r[s+1].v <= dl_r[s].v;
      dl_r[s+1].op  <= dl_r[s].op;
      dl_r[s+1].vx  <= dl_r[s].vx;
      dl_r[s+1].sc  <= dl_r[s].sc;
      dl_r[s+1].sat <= dl_r[s].sat;
      dl_r[s+1].a   <= dl_r[s].a;
    end
  end

  logic [ROOT_W-1:0] root;
  v3a_sqrt #(.STAGES(SQ_ST)) u_sqrt (.clk, .en, .n_in(ssq_r), .root(root));

  // numerators are formed from the delayed a at the root output
  logic [NUM_W-1:0]  num [3];
  logic [NUM_W-1:0]  quo [3];
  logic [ROOT_W-1:0] len_d_r [NUM_W+1];
  logic [ROOT_W-1:0] den;
  assign den = (root == '0) ? ROOT_W'(1) : root;
  always_comb len_d_r[0] = root;
  for (genvar s = 0; s < NUM_W; s++) begin : g_ld
    always_ff @(posedge clk) len_d_r[s+1] <= len_d_r[s];
  end

  for (genvar i = 0; i < 3; i++) begin : g_div
    logic signed [DATA_W-1:0] ai;
    logic [DATA_W-1:0]        m;
    assign ai  = dl_r[SQ_ST].a[i*DATA_W +: DATA_W];
    assign m   = ai[DATA_W-1] ? DATA_W'(-ai) : ai;
    assign num[i] = (NUM_W'(m) << FRAC_BITS) + NUM_W'(root >> 1);
    v3a_div #(.NUM_W(NUM_W), .DEN_W(ROOT_W)) u_div (.clk, .en, .num(num[i]),
      .den(den), .quo(quo[i]));
  end

  // final select
  dl_t               fin;
  logic [ROOT_W-1:0] flen;
  logic [DATA_W-1:0] out_r_x_nxt, out_r_y_nxt, out_r_z_nxt, out_scalar_out_nxt;
  logic              out_saturated_nxt;
  assign fin  = dl_r[TAIL];
  assign flen = len_d_r[NUM_W];

  always_comb begin
    out_r_x_nxt        = fin.vx[0 +: DATA_W];
    out_r_y_nxt        = fin.vx[DATA_W +: DATA_W];
    out_r_z_nxt        = fin.vx[2*DATA_W +: DATA_W];
    out_scalar_out_nxt = fin.sc;
    out_saturated_nxt  = fin.sat;
    case (fin.op)
      OP_LEN: begin
        out_r_x_nxt = '0;
        out_r_y_nxt = '0;
        out_r_z_nxt = '0;
        // length above the largest positive value clips
        if (flen[ROOT_W-1] || flen[DATA_W-1]) begin
          out_scalar_out_nxt = 32'h7FFF_FFFF;
          out_saturated_nxt  = 1'b1;
        end else begin
          out_scalar_out_nxt = flen[DATA_W-1:0];
          out_saturated_nxt  = 1'b0;
        end
      end
      OP_NORM: begin
        out_scalar_out_nxt = '0;
        out_saturated_nxt  = 1'b0;
        if (flen == '0) begin
          out_r_x_nxt = fin.a[0 +: DATA_W];
          out_r_y_nxt = fin.a[DATA_W +: DATA_W];
          out_r_z_nxt = fin.a[2*DATA_W +: DATA_W];
        end else begin
          out_r_x_nxt = fin.a[DATA_W-1] ? DATA_W'(-quo[0]) : quo[0][DATA_W-1:0];
          out_r_y_nxt = fin.a[2*DATA_W-1] ? DATA_W'(-quo[1]) : quo[1][DATA_W-1:0];
          out_r_z_nxt = fin.a[3*DATA_W-1] ? DATA_W'(-quo[2]) : quo[2][DATA_W-1:0];
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid <= 1'b0;
    else        out_valid <= fin.v;
    out_r_x        <= out_r_x_nxt;
    out_r_y        <= out_r_y_nxt;
    out_r_z        <= out_r_z_nxt;
    out_scalar_out <= out_scalar_out_nxt;
    out_saturated  <= out_saturated_nxt;
  end

`ifndef SYNTH
  a_lat: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> ##(DEPTH+1) out_valid) else $error("result beat missing");
  a_len_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_saturated |-> $past(fin.op) != OP_NORM) else $error("norm sat");
  a_busy: assert property (@(posedge clk) !busy) else $error("busy raised");
`endif

endmodule
`default_nettype wire

// ===== hdl/v3a_lane.sv =====
// ----------------------------------------------------------------------------
// v3a_lane
// one component lane: add/sub/negate, two products and its own a component's square
// ----------------------------------------------------------------------------
`default_nettype none
module v3a_lane import v3a_pkg::*; (
  input  wire logic                     clk,
  input  wire logic                     en,
  input  wire logic [2:0]               op,
  input  wire logic signed [DATA_W-1:0] a_self,
  input  wire logic signed [DATA_W-1:0] b_self,
  input  wire logic signed [DATA_W-1:0] a_p,
  input  wire logic signed [DATA_W-1:0] b_q,
  input  wire logic signed [DATA_W-1:0] b_p,
  input  wire logic signed [DATA_W-1:0] a_q,
  input  wire logic signed [DATA_W-1:0] s_val,
  output lane_res_t                     res,
  output logic [PROD_W-1:0]             sq
);

  logic signed [PROD_W-1:0] p0_r, p1_r;
  logic signed [PROD_W-1:0] p0_nxt, p1_nxt;
  logic signed [DATA_W:0]   lin_r, lin_nxt;
  logic [2:0]               op_r;
  logic signed [DATA_W-1:0] a_r;
  logic [PROD_W-1:0]        sq_r;
  logic [DATA_W-1:0]        mag_a;

  assign mag_a = a_self[DATA_W-1] ? DATA_W'(-a_self) : a_self;

  always_comb begin
    p0_nxt  = '0;
    p1_nxt  = '0;
    lin_nxt = '0;
    case (op)
      OP_ADD:   lin_nxt = (DATA_W+1)'(a_self) + (DATA_W+1)'(b_self);
      OP_SUB:   lin_nxt = (DATA_W+1)'(a_self) - (DATA_W+1)'(b_self);
      OP_NEG:   lin_nxt = -(DATA_W+1)'(a_self);
      OP_SCALE: p0_nxt = PROD_W'(a_self) * PROD_W'(s_val);
      OP_DOT:   p0_nxt = PROD_W'(a_self) * PROD_W'(b_self);
      OP_CROSS: begin
        p0_nxt = PROD_W'(a_p) * PROD_W'(b_q);
        p1_nxt = PROD_W'(b_p) * PROD_W'(a_q);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p0_r  <= p0_nxt;
      p1_r  <= p1_nxt;
      lin_r <= lin_nxt;
      op_r  <= op;
      a_r   <= a_self;
      sq_r  <= PROD_W'(mag_a) * PROD_W'(mag_a);
    end
  end

  always_comb begin
    res.a_val = a_r;
    case (op_r)
      OP_ADD, OP_SUB, OP_NEG: res.acc = (PROD_W+2)'(lin_r);
      OP_CROSS: res.acc = (PROD_W+2)'(p0_r) - (PROD_W+2)'(p1_r);
      default:  res.acc = (PROD_W+2)'(p0_r);
    endcase
  end
  assign sq = sq_r;

endmodule
`default_nettype wire

// ===== hdl/v3a_sqrt.sv =====
// ----------------------------------------------------------------------------
// v3a_sqrt
// pipelined rounded integer square root, two result bits per stage
// ----------------------------------------------------------------------------
`default_nettype none
module v3a_sqrt import v3a_pkg::*; #(
  parameter int STAGES = ROOT_W / 2 + 1
) (
  input  wire logic            clk,
  input  wire logic            en,
  input  wire logic [SQ_W-1:0] n_in,
  output logic [ROOT_W-1:0]    root
);

  localparam int NB = 2 * STAGES;  // bits of root produced, >= ROOT_W

  logic [SQ_W-1:0]   rem_r  [STAGES+1];
  logic [ROOT_W:0]   q_r    [STAGES+1];
  logic [SQ_W-1:0]   n_r    [STAGES+1];

  always_comb begin
    rem_r[0] = '0;
    q_r[0]   = '0;
    n_r[0]   = n_in;
  end

  for (genvar s = 0; s < STAGES; s++) begin : g_st
    logic [SQ_W+1:0] rem_w;
    logic [ROOT_W:0] q_w;
    logic [SQ_W-1:0] rem_nxt;
    logic [ROOT_W:0] q_nxt;
    always_comb begin
      rem_w = {rem_r[s], 2'b00};
      q_w   = q_r[s];
      rem_nxt = '0;
      q_nxt   = '0;
      for (int k = 0; k < 2; k++) begin
        logic [SQ_W+1:0] trial;
        int bi;
        bi = NB - 1 - 2 * s - k;
        trial = rem_w | (SQ_W+2)'((bi < SQ_W/2) ? n_r[s][2*bi +: 2] : 2'b00);
        trial = (k == 0) ? trial : {rem_w[SQ_W-1:0], 2'b00}
                | (SQ_W+2)'((bi < SQ_W/2) ? n_r[s][2*bi +: 2] : 2'b00);
        if (trial >= (SQ_W+2)'({q_w, 2'b01})) begin
          rem_w = trial - (SQ_W+2)'({q_w, 2'b01});
          q_w   = {q_w[ROOT_W-1:0], 1'b1};
        end else begin
          rem_w = trial;
          q_w   = {q_w[ROOT_W-1:0], 1'b0};
        end
        if (k == 0) rem_w = rem_w;
      end
      rem_nxt = rem_w[SQ_W-1:0];
      q_nxt   = q_w;
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[s+1] <= rem_nxt;
        q_r[s+1]   <= q_nxt;
        n_r[s+1]   <= n_r[s];
      end
    end
  end

  // round to nearest: remainder above root means bump
  assign root = ROOT_W'(q_r[STAGES]) +
                ROOT_W'((SQ_W+1)'(rem_r[STAGES]) > (SQ_W+1)'(q_r[STAGES]));

endmodule
`default_nettype wire

// ===== hdl/v3a_div.sv =====
// ----------------------------------------------------------------------------
// v3a_div
// pipelined restoring divider, one quotient bit per stage
// ----------------------------------------------------------------------------
`default_nettype none
module v3a_div import v3a_pkg::*; #(
  parameter int NUM_W = 49,
  parameter int DEN_W = ROOT_W
) (
  input  wire logic             clk,
  input  wire logic             en,
  input  wire logic [NUM_W-1:0] num,
  input  wire logic [DEN_W-1:0] den,
  output logic [NUM_W-1:0]      quo
);

  logic [NUM_W-1:0] q_r   [NUM_W+1];
  logic [DEN_W:0]   rem_r [NUM_W+1];
  logic [NUM_W-1:0] n_r   [NUM_W+1];
  logic [DEN_W-1:0] d_r   [NUM_W+1];

  always_comb begin
    q_r[0]   = '0;
    rem_r[0] = '0;
    n_r[0]   = num;
    d_r[0]   = den;
  end

  for (genvar s = 0; s < NUM_W; s++) begin : g_st
    logic [DEN_W+1:0] t;
    always_comb t = {rem_r[s], n_r[s][NUM_W-1-s]};
    always_ff @(posedge clk) begin
      if (en) begin
        if (t >= (DEN_W+2)'(d_r[s])) begin
          rem_r[s+1] <= (DEN_W+1)'(t - (DEN_W+2)'(d_r[s]));
          q_r[s+1]   <= q_r[s] | (NUM_W'(1) << (NUM_W-1-s));
        end else begin
          rem_r[s+1] <= t[DEN_W:0];
          q_r[s+1]   <= q_r[s];
        end
        n_r[s+1] <= n_r[s];
        d_r[s+1] <= d_r[s];
      end
    end
  end

  assign quo = q_r[NUM_W];

endmodule
`default_nettype wire
